// ===== rtl/core/water_site_placement_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the water site placement block
// ---------------------------------------------------------------------------
`ifndef WATER_SITE_PLACEMENT_MACROS_SVH
`define WATER_SITE_PLACEMENT_MACROS_SVH

// Same-cycle implication, checked only out of reset
`define WSP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay, checked only out of reset
`define WSP_ASSERT_DELAYED(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wsp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsp_pkg
// Shared widths, constants, register indexes and pipeline types of the
// water site placement block.
// ---------------------------------------------------------------------------
package wsp_pkg;

    localparam int COORD_W      = 32;
    localparam int ORIENT_W     = 16;
    localparam int CFG_W        = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int TRIG_W       = 32;   // signed Q.30 sine / cosine
    localparam int Z_W          = 34;   // residual angle, 2^-32 turn units
    localparam int ANGLE_W      = 32;
    localparam int PROD_FRAC    = 46;
    localparam int PROD_W       = CFG_W + 1 + TRIG_W;
    localparam int SUM_W        = PROD_W + 2;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    localparam logic [CFG_IDX_W-1:0] CFG_COS_HALF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_HALF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COM_OFFS  = 2'd2;

    localparam logic [CFG_W-1:0] COS_HALF_RESET = 17'd40115;
    localparam logic [CFG_W-1:0] SIN_HALF_RESET = 17'd51826;
    localparam logic [CFG_W-1:0] COM_OFFS_RESET = 17'd4457;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [TRIG_W-1:0]  x;
        logic signed [TRIG_W-1:0]  y;
        logic signed [Z_W-1:0]     z;
        logic                      flip;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } cordic_data_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  cos_t;
        logic signed [TRIG_W-1:0]  sin_t;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } trig_t;

    typedef struct packed {
        logic [CFG_W-1:0] cos_half;
        logic [CFG_W-1:0] sin_half;
        logic [CFG_W-1:0] com_offs;
    } cfg_regs_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] hax;
        logic signed [COORD_W-1:0] hay;
        logic signed [COORD_W-1:0] hbx;
        logic signed [COORD_W-1:0] hby;
    } sites_t;

endpackage

// ===== rtl/core/wsp_cordic_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsp_cordic_stage
// One registered CORDIC micro-rotation in rotation mode.
// ---------------------------------------------------------------------------
module wsp_cordic_stage #(
    parameter int STAGE_IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  wsp_pkg::cordic_data_t in_data,
    output logic                  out_valid,
    output wsp_pkg::cordic_data_t out_data
);

    localparam logic signed [wsp_pkg::Z_W-1:0] ATAN_STEP =
        wsp_pkg::Z_W'(wsp_pkg::ATAN_TURNS[STAGE_IDX]);

    logic                  valid_reg;
    wsp_pkg::cordic_data_t data_reg;
    wsp_pkg::cordic_data_t data_next;
    logic signed [wsp_pkg::TRIG_W-1:0] x_sh;
    logic signed [wsp_pkg::TRIG_W-1:0] y_sh;

    always_comb
    begin
        x_sh      = in_data.x >>> STAGE_IDX;
        y_sh      = in_data.y >>> STAGE_IDX;
        data_next = in_data;
        if (!in_data.z[wsp_pkg::Z_W-1])
        begin
            data_next.x = in_data.x - y_sh;
            data_next.y = in_data.y + x_sh;
            data_next.z = in_data.z - ATAN_STEP;
        end
        else
        begin
            data_next.x = in_data.x + y_sh;
            data_next.y = in_data.y - x_sh;
            data_next.z = in_data.z + ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/wsp_cordic.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsp_cordic
// Pipelined sine / cosine unit: quadrant fold, one stage per iteration,
// then sign restore. Carries the molecule centre alongside.
// ---------------------------------------------------------------------------
module wsp_cordic #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [wsp_pkg::COORD_W-1:0]  center_x,
    input  logic signed [wsp_pkg::COORD_W-1:0]  center_y,
    input  logic [wsp_pkg::ORIENT_W-1:0]        orientation,
    output logic                                out_valid,
    output wsp_pkg::trig_t                      out_data
);

    localparam int NUM_ITER = (TRIG_ITERATIONS < wsp_pkg::ATAN_ENTRIES) ?
                              TRIG_ITERATIONS : wsp_pkg::ATAN_ENTRIES;

    logic                                 prep_flip;
    logic [wsp_pkg::ORIENT_W-1:0]         prep_angle;
    logic [wsp_pkg::ANGLE_W-1:0]          prep_z;
    wsp_pkg::cordic_data_t                prep_next;

    logic                                 prep_valid_reg;
    wsp_pkg::cordic_data_t                prep_reg;

    logic                                 chain_valid [NUM_ITER+1];
    wsp_pkg::cordic_data_t                chain_data  [NUM_ITER+1];

    logic                                 post_valid_reg;
    wsp_pkg::trig_t                       post_reg;
    wsp_pkg::trig_t                       post_next;

    // fold the left half-plane onto the right one
    always_comb
    begin
        prep_flip      = orientation inside {[16'd16384:16'd49151]};
        prep_angle     = {orientation[wsp_pkg::ORIENT_W-1] ^ prep_flip,
                          orientation[wsp_pkg::ORIENT_W-2:0]};
        prep_z         = {prep_angle, {(wsp_pkg::ANGLE_W-wsp_pkg::ORIENT_W){1'b0}}};
        prep_next.x    = wsp_pkg::CORDIC_GAIN_Q30;
        prep_next.y    = '0;
        prep_next.z    = wsp_pkg::Z_W'(signed'(prep_z));
        prep_next.flip = prep_flip;
        prep_next.cx   = center_x;
        prep_next.cy   = center_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
            post_valid_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= in_valid;
            post_valid_reg <= chain_valid[NUM_ITER];
        end
    end

    always_ff @(posedge clk)
    begin
        prep_reg <= prep_next;
        post_reg <= post_next;
    end

    assign chain_valid[0] = prep_valid_reg;
    assign chain_data[0]  = prep_reg;

    for (genvar g = 0; g < NUM_ITER; g++)
    begin : g_iter
        wsp_cordic_stage #(
            .STAGE_IDX (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    // undo the half-turn fold
    always_comb
    begin
        post_next.cos_t = chain_data[NUM_ITER].flip ? -chain_data[NUM_ITER].x
                                                    :  chain_data[NUM_ITER].x;
        post_next.sin_t = chain_data[NUM_ITER].flip ? -chain_data[NUM_ITER].y
                                                    :  chain_data[NUM_ITER].y;
        post_next.cx    = chain_data[NUM_ITER].cx;
        post_next.cy    = chain_data[NUM_ITER].cy;
    end

    assign out_valid = post_valid_reg;
    assign out_data  = post_reg;

endmodule

// ===== rtl/core/wsp_combine.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsp_combine
// Scales the trig results by the configured constants, rounds to the
// coordinate format and places the oxygen and hydrogen sites.
// ---------------------------------------------------------------------------
module wsp_combine #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  wsp_pkg::trig_t     in_data,
    input  wsp_pkg::cfg_regs_t cfg,
    output logic               out_valid,
    output wsp_pkg::sites_t    out_data
);

    localparam int SHIFT = wsp_pkg::PROD_FRAC - COORD_FRAC_BITS;
    localparam logic signed [wsp_pkg::SUM_W-1:0] HALF_LSB =
        wsp_pkg::SUM_W'(1) <<< (SHIFT - 1);

    typedef logic signed [wsp_pkg::PROD_W-1:0]  prod_t;
    typedef logic signed [wsp_pkg::SUM_W-1:0]   sum_t;
    typedef logic signed [wsp_pkg::COORD_W-1:0] coord_t;

    function automatic coord_t round_coord(input sum_t v);
        sum_t t;
        t = (v + HALF_LSB) >>> SHIFT;
        return t[wsp_pkg::COORD_W-1:0];
    endfunction

    // product stage
    logic   mul_valid_reg;
    prod_t  p_ox_reg, p_oy_reg, p_cc_reg, p_ss_reg, p_sc_reg, p_cs_reg;
    coord_t mul_cx_reg, mul_cy_reg;
    logic signed [wsp_pkg::CFG_W:0] com_s, ch_s, sh_s;

    // rounding stage
    logic   rnd_valid_reg;
    coord_t ox_off_reg, oy_off_reg, ha_dx_reg, ha_dy_reg, hb_dx_reg, hb_dy_reg;
    coord_t rnd_cx_reg, rnd_cy_reg;

    // oxygen stage
    logic   oxy_valid_reg;
    coord_t ox_reg, oy_reg;
    coord_t oxy_ha_dx_reg, oxy_ha_dy_reg, oxy_hb_dx_reg, oxy_hb_dy_reg;

    // hydrogen / output stage
    logic            out_valid_reg;
    wsp_pkg::sites_t sites_reg;
    wsp_pkg::sites_t sites_next;

    assign com_s = signed'({1'b0, cfg.com_offs});
    assign ch_s  = signed'({1'b0, cfg.cos_half});
    assign sh_s  = signed'({1'b0, cfg.sin_half});

    always_comb
    begin
        sites_next.ox  = ox_reg;
        sites_next.oy  = oy_reg;
        sites_next.hax = ox_reg - oxy_ha_dx_reg;
        sites_next.hay = oy_reg + oxy_ha_dy_reg;
        sites_next.hbx = ox_reg - oxy_hb_dx_reg;
        sites_next.hby = oy_reg - oxy_hb_dy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            rnd_valid_reg <= 1'b0;
            oxy_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            rnd_valid_reg <= mul_valid_reg;
            oxy_valid_reg <= rnd_valid_reg;
            out_valid_reg <= oxy_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_ox_reg      <= com_s * in_data.cos_t;
        p_oy_reg      <= com_s * in_data.sin_t;
        p_cc_reg      <= ch_s * in_data.cos_t;
        p_ss_reg      <= sh_s * in_data.sin_t;
        p_sc_reg      <= sh_s * in_data.cos_t;
        p_cs_reg      <= ch_s * in_data.sin_t;
        mul_cx_reg    <= in_data.cx;
        mul_cy_reg    <= in_data.cy;

        ox_off_reg    <= round_coord(sum_t'(p_ox_reg));
        oy_off_reg    <= round_coord(sum_t'(p_oy_reg));
        ha_dx_reg     <= round_coord(sum_t'(p_cc_reg) + sum_t'(p_ss_reg));
        ha_dy_reg     <= round_coord(sum_t'(p_sc_reg) - sum_t'(p_cs_reg));
        hb_dx_reg     <= round_coord(sum_t'(p_cc_reg) - sum_t'(p_ss_reg));
        hb_dy_reg     <= round_coord(sum_t'(p_sc_reg) + sum_t'(p_cs_reg));
        rnd_cx_reg    <= mul_cx_reg;
        rnd_cy_reg    <= mul_cy_reg;

        ox_reg        <= rnd_cx_reg + ox_off_reg;
        oy_reg        <= rnd_cy_reg + oy_off_reg;
        oxy_ha_dx_reg <= ha_dx_reg;
        oxy_ha_dy_reg <= ha_dy_reg;
        oxy_hb_dx_reg <= hb_dx_reg;
        oxy_hb_dy_reg <= hb_dy_reg;

        sites_reg     <= sites_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = sites_reg;

endmodule

// ===== rtl/core/water_site_placement.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// water_site_placement
// Oxygen and hydrogen site positions of a rigid 2D water molecule from its
// centre and orientation.
// ---------------------------------------------------------------------------
// Takes one molecule every clock cycle: busy never rises, so a start is
// always accepted. Each transaction produces one result, shown for a single
// cycle with done high; results leave in order and cannot be held off, so the
// receiver must take every one. Each molecule passes through a fold stage,
// one CORDIC register stage per micro-rotation, then sign restore, multiply,
// round and two placement stages. Configuration writes are always ready and
// act at once on items in flight, so write them only with the pipeline empty.
// ---------------------------------------------------------------------------
module water_site_placement #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [wsp_pkg::COORD_W-1:0]   center_x,
    input  logic signed [wsp_pkg::COORD_W-1:0]   center_y,
    input  logic [wsp_pkg::ORIENT_W-1:0]         orientation,
    output logic                                 done,
    output logic signed [wsp_pkg::COORD_W-1:0]   oxygen_x,
    output logic signed [wsp_pkg::COORD_W-1:0]   oxygen_y,
    output logic signed [wsp_pkg::COORD_W-1:0]   hydrogen_a_x,
    output logic signed [wsp_pkg::COORD_W-1:0]   hydrogen_a_y,
    output logic signed [wsp_pkg::COORD_W-1:0]   hydrogen_b_x,
    output logic signed [wsp_pkg::COORD_W-1:0]   hydrogen_b_y,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wsp_pkg::CFG_W-1:0]            cfg_data
);

    localparam int NUM_ITER = (TRIG_ITERATIONS < wsp_pkg::ATAN_ENTRIES) ?
                              TRIG_ITERATIONS : wsp_pkg::ATAN_ENTRIES;
    localparam int LATENCY  = NUM_ITER + 6;

    wsp_pkg::cfg_regs_t cfg_reg;
    logic               trig_valid;
    wsp_pkg::trig_t     trig_data;
    logic               sites_valid;
    wsp_pkg::sites_t    sites;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // indexes beyond the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_half <= wsp_pkg::COS_HALF_RESET;
            cfg_reg.sin_half <= wsp_pkg::SIN_HALF_RESET;
            cfg_reg.com_offs <= wsp_pkg::COM_OFFS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wsp_pkg::CFG_COS_HALF: cfg_reg.cos_half <= cfg_data;
                wsp_pkg::CFG_SIN_HALF: cfg_reg.sin_half <= cfg_data;
                wsp_pkg::CFG_COM_OFFS: cfg_reg.com_offs <= cfg_data;
                default:               cfg_reg          <= cfg_reg;
            endcase
        end
    end

    wsp_cordic #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .center_x    (center_x),
        .center_y    (center_y),
        .orientation (orientation),
        .out_valid   (trig_valid),
        .out_data    (trig_data)
    );

    wsp_combine #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .in_data   (trig_data),
        .cfg       (cfg_reg),
        .out_valid (sites_valid),
        .out_data  (sites)
    );

    assign done         = sites_valid;
    assign oxygen_x     = sites.ox;
    assign oxygen_y     = sites.oy;
    assign hydrogen_a_x = sites.hax;
    assign hydrogen_a_y = sites.hay;
    assign hydrogen_b_x = sites.hbx;
    assign hydrogen_b_y = sites.hby;

endmodule

// ===== rtl/core/wsp_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsp_checker
// Port-level checks of the water site placement block: fixed latency
// between start and done, and an always-ready configuration port.
// ---------------------------------------------------------------------------
`include "water_site_placement_macros.svh"

module wsp_checker #(
    parameter int LATENCY = 22
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_valid,
    input logic cfg_ready
);

    // every accepted transaction yields exactly one result, and no result appears without one
    `WSP_ASSERT_DELAYED(a_accept_gives_done, start && !busy, LATENCY, done, "result missing after accepted start")
    `WSP_ASSERT_IMPLY(a_done_has_accept, done, $past(start && !busy, LATENCY), "result without matching start")
    `WSP_ASSERT_IMPLY(a_cfg_never_stalls, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind water_site_placement wsp_checker #(
    .LATENCY (LATENCY)
) u_wsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ===== verif/tb_water_site_placement.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_water_site_placement
// Self-checking bench for the water site placement block: drives molecule
// centres and orientations, predicts the oxygen and hydrogen sites with a
// local CORDIC and fixed-point model, and checks every result in order.
// Runs under several geometry settings, including the register extremes.
// ---------------------------------------------------------------------------
module tb_water_site_placement;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int LATENCY      = (CORDIC_STEPS < 24 ? CORDIC_STEPS : 24) + 6;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int GAP_PCT      = 28;
    localparam longint GAIN_Q30 = 652032874;
    localparam logic [wsp_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // atan(2^-i), 2^-32 turn units
    localparam longint ATAN_STEP [24] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331,  21354465,  10679838,  5340245,
        2670163,   1335087,   667544,    333772,
        166886,    83443,     41722,     20861,
        10430,     5215,      2608,      1304,
        652,       326,       163,       81
    };

    typedef struct {
        logic signed [wsp_pkg::COORD_W-1:0] cx;
        logic signed [wsp_pkg::COORD_W-1:0] cy;
        logic [wsp_pkg::ORIENT_W-1:0]       orient;
    } molecule_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic signed [wsp_pkg::COORD_W-1:0]   center_x = '0;
    logic signed [wsp_pkg::COORD_W-1:0]   center_y = '0;
    logic [wsp_pkg::ORIENT_W-1:0]         orientation = '0;
    logic                                 done;
    logic signed [wsp_pkg::COORD_W-1:0]   oxygen_x;
    logic signed [wsp_pkg::COORD_W-1:0]   oxygen_y;
    logic signed [wsp_pkg::COORD_W-1:0]   hydrogen_a_x;
    logic signed [wsp_pkg::COORD_W-1:0]   hydrogen_a_y;
    logic signed [wsp_pkg::COORD_W-1:0]   hydrogen_b_x;
    logic signed [wsp_pkg::COORD_W-1:0]   hydrogen_b_y;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [wsp_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [wsp_pkg::CFG_W-1:0]            cfg_data = '0;

    molecule_t                 pending_molecules[$];
    wsp_pkg::sites_t           sites_due[$];
    logic [wsp_pkg::CFG_W-1:0] cos_half_cfg = wsp_pkg::COS_HALF_RESET;
    logic [wsp_pkg::CFG_W-1:0] sin_half_cfg = wsp_pkg::SIN_HALF_RESET;
    logic [wsp_pkg::CFG_W-1:0] com_offs_cfg = wsp_pkg::COM_OFFS_RESET;
    int          gap_pct = GAP_PCT;
    int          errors = 0;
    int          cycle_count = 0;

    water_site_placement #(
        .COORD_FRAC_BITS(FRAC_BITS),
        .TRIG_ITERATIONS(CORDIC_STEPS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .center_x(center_x),
        .center_y(center_y),
        .orientation(orientation),
        .done(done),
        .oxygen_x(oxygen_x),
        .oxygen_y(oxygen_y),
        .hydrogen_a_x(hydrogen_a_x),
        .hydrogen_a_y(hydrogen_a_y),
        .hydrogen_b_x(hydrogen_b_x),
        .hydrogen_b_y(hydrogen_b_y),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cos t and sin t in Q.30; fold the left half-plane by a half turn first
    function automatic void rotate_angle(input logic [wsp_pkg::ORIENT_W-1:0] orient,
                                         output longint cos_t, output longint sin_t);
        longint x, y, z, nx, ny;
        logic [wsp_pkg::ORIENT_W-1:0] a;
        bit flip;
        x = GAIN_Q30;
        y = 0;
        a = orient;
        flip = 1'b0;
        if (a >= 16384 && a < 49152)
        begin
            a = a + 16'd32768;
            flip = 1'b1;
        end
        z = longint'($signed(a)) * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_STEP[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_STEP[i];
            end
            x = nx;
            y = ny;
        end
        cos_t = flip ? -x : x;
        sin_t = flip ? -y : y;
    endfunction

    // Q.46 product to coordinate fraction bits, round half up
    function automatic logic [wsp_pkg::COORD_W-1:0] round_coord(input longint v);
        longint r;
        r = (v + (longint'(1) <<< (wsp_pkg::PROD_FRAC - FRAC_BITS - 1)))
            >>> (wsp_pkg::PROD_FRAC - FRAC_BITS);
        return r[wsp_pkg::COORD_W-1:0];
    endfunction

    function automatic wsp_pkg::sites_t place_sites(input molecule_t m);
        wsp_pkg::sites_t s;
        longint ct, st, ch, sh, co;
        rotate_angle(m.orient, ct, st);
        ch = longint'(cos_half_cfg);
        sh = longint'(sin_half_cfg);
        co = longint'(com_offs_cfg);
        s.ox  = m.cx + round_coord(co * ct);
        s.oy  = m.cy + round_coord(co * st);
        s.hax = s.ox - round_coord(ch * ct + sh * st);
        s.hay = s.oy + round_coord(sh * ct - ch * st);
        s.hbx = s.ox - round_coord(ch * ct - sh * st);
        s.hby = s.oy - round_coord(sh * ct + ch * st);
        return s;
    endfunction

    // Driver: present the next molecule, hold it while busy
    always @(posedge clk or negedge rst_n)
    begin
        molecule_t m;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                m.cx = center_x;
                m.cy = center_y;
                m.orient = orientation;
                sites_due.push_back(place_sites(m));
            end
            if (!start || !busy)
            begin
                if (pending_molecules.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    m = pending_molecules.pop_front();
                    start       <= 1'b1;
                    center_x    <= m.cx;
                    center_y    <= m.cy;
                    orientation <= m.orient;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [wsp_pkg::COORD_W-1:0] want,
                               input logic [wsp_pkg::COORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Monitor: results cannot be held off, take one whenever done is high
    always @(posedge clk)
    begin
        wsp_pkg::sites_t want;
        if (rst_n && done)
        begin
            if (sites_due.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual oxygen_x %h",
                         $time, oxygen_x);
                errors++;
            end
            else
            begin
                want = sites_due.pop_front();
                check_field("oxygen_x", want.ox, oxygen_x);
                check_field("oxygen_y", want.oy, oxygen_y);
                check_field("hydrogen_a_x", want.hax, hydrogen_a_x);
                check_field("hydrogen_a_y", want.hay, hydrogen_a_y);
                check_field("hydrogen_b_x", want.hbx, hydrogen_b_x);
                check_field("hydrogen_b_y", want.hby, hydrogen_b_y);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic write_register(input logic [wsp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [wsp_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            wsp_pkg::CFG_COS_HALF: cos_half_cfg = value;
            wsp_pkg::CFG_SIN_HALF: sin_half_cfg = value;
            wsp_pkg::CFG_COM_OFFS: com_offs_cfg = value;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [wsp_pkg::CFG_W-1:0] cos_h,
                                input logic [wsp_pkg::CFG_W-1:0] sin_h,
                                input logic [wsp_pkg::CFG_W-1:0] com);
        write_register(wsp_pkg::CFG_COS_HALF, cos_h);
        write_register(wsp_pkg::CFG_SIN_HALF, sin_h);
        write_register(wsp_pkg::CFG_COM_OFFS, com);
    endtask

    task automatic push_molecule(input logic [wsp_pkg::COORD_W-1:0] cx,
                                 input logic [wsp_pkg::COORD_W-1:0] cy,
                                 input logic [wsp_pkg::ORIENT_W-1:0] orient);
        molecule_t m;
        m.cx = cx;
        m.cy = cy;
        m.orient = orient;
        pending_molecules.push_back(m);
    endtask

    function automatic logic [wsp_pkg::COORD_W-1:0] random_coord();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 32'h7FFF_0000 + $urandom_range(65535)
                                        : 32'h8000_0000 + $urandom_range(65535);
            1: return $urandom_range(262144) - 131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [wsp_pkg::ORIENT_W-1:0] random_orient();
        logic [wsp_pkg::ORIENT_W-1:0] edges [8] = '{16'd0, 16'd16383, 16'd16384, 16'd32767,
                                                   16'd32768, 16'd49151, 16'd49152,
                                                   16'd65535};
        if ($urandom_range(3) == 0)
            return wsp_pkg::ORIENT_W'(edges[$urandom_range(7)] + $urandom_range(2) - 1);
        return wsp_pkg::ORIENT_W'($urandom_range(65535));
    endfunction

    // Wait for the pipe to empty, then let any stray result surface
    task automatic wait_drained();
        do @(posedge clk);
        while (pending_molecules.size() != 0 || start || sites_due.size() != 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic run_batch(input int count, input int gap);
        gap_pct = gap;
        repeat (count)
            push_molecule(random_coord(), random_coord(), random_orient());
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: quadrant fold boundaries, coordinate extremes and wrap
        gap_pct = 0;
        push_molecule(32'h0000_0000, 32'h0000_0000, 16'd0);
        push_molecule(32'h0000_0000, 32'h0000_0000, 16'd16383);
        push_molecule(32'h0000_0000, 32'h0000_0000, 16'd16384);
        push_molecule(32'h0000_0000, 32'h0000_0000, 16'd32767);
        push_molecule(32'h0000_0000, 32'h0000_0000, 16'd32768);
        push_molecule(32'h0000_0000, 32'h0000_0000, 16'd49151);
        push_molecule(32'h0000_0000, 32'h0000_0000, 16'd49152);
        push_molecule(32'h0000_0000, 32'h0000_0000, 16'd65535);
        push_molecule(32'h0001_0000, 32'hFFFF_0000, 16'd8192);
        push_molecule(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0);
        push_molecule(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd8192);
        push_molecule(32'h8000_0000, 32'h8000_0000, 16'd32768);
        push_molecule(32'h8000_0000, 32'h8000_0000, 16'd40960);
        push_molecule(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd24576);
        push_molecule(32'h7FFF_FFFF, 32'h8000_0000, 16'd57344);
        push_molecule(32'h8000_0000, 32'h7FFF_FFFF, 16'd16384);
        wait_drained();
        run_batch(130, GAP_PCT);

        // Register extremes, including values above one
        set_geometry(17'd65536, 17'd0, 17'd0);
        run_batch(120, GAP_PCT);
        set_geometry(17'd0, 17'd65536, 17'd65536);
        run_batch(120, 0);
        set_geometry(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        run_batch(120, GAP_PCT);

        // Unmapped index: writes must leave the geometry alone
        write_register(CFG_UNMAPPED, 17'h1FFFF);
        write_register(CFG_UNMAPPED, 17'd0);
        run_batch(100, GAP_PCT);

        repeat (3)
        begin
            set_geometry(wsp_pkg::CFG_W'($urandom_range(65536)),
                         wsp_pkg::CFG_W'($urandom_range(65536)),
                         wsp_pkg::CFG_W'($urandom_range(131071)));
            run_batch(120, GAP_PCT);
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/wsp_pkg.sv
rtl/core/wsp_cordic_stage.sv
rtl/core/wsp_cordic.sv
rtl/core/wsp_combine.sv
rtl/core/water_site_placement.sv
rtl/core/wsp_checker.sv
verif/tb_water_site_placement.sv
